@@ hw/rtl/mtrg_pkg.sv @@
package mtrg_pkg;

    localparam int TABLE_WORDS  = 624;
    localparam int TWIST_OFFSET = 397;
    localparam int ADDR_W       = $clog2(TABLE_WORDS);
    localparam int CNT_W        = $clog2(TABLE_WORDS + 1);

    localparam logic [31:0] MATRIX_A   = 32'h9908_B0DF;
    localparam logic [31:0] TEMPER_B   = 32'h9D2C_5680;
    localparam logic [31:0] TEMPER_C   = 32'hEFC6_0000;
    localparam logic [31:0] SEED_MULT  = 32'd69069;
    localparam logic [31:0] UPPER_MASK = 32'h8000_0000;
    localparam logic [31:0] LOWER_MASK = 32'h7FFF_FFFF;
    localparam logic [31:0] SEED_RESET = 32'd4357;

    function automatic logic [31:0] temper(input logic [31:0] y_in);
        logic [31:0] y;
        y = y_in;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

@@ hw/rtl/mtrg_output_stage.sv @@
module mtrg_output_stage
    import mtrg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  logic [31:0] raw_word,
    output logic        done,
    output logic [31:0] word
);

    logic        done_reg;
    logic [31:0] word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= temper(raw_word);
        end
    end

    assign done = done_reg;
    assign word = word_reg;

endmodule

@@ hw/rtl/mt19937_random_generator.sv @@
// MT19937 word source. A request (start high while busy is low) returns one
// tempered 32-bit word, shown on random_word with done high for exactly one
// cycle. For a plain read the word passes the registered table read port and
// then the output stage register. The receiver cannot stall it. Plain reads
// go one per cycle: busy stays low while a read is in flight. When all 624
// table words have been handed out, the next request runs a twist pass over
// the table memory (one word per cycle) before its word is read. The first
// request after reset, or any request with reseed set, first fills the table
// from the seed register (one multiply per word) and then twists. There is
// no clearing pass after reset. The seed register can be written at any idle
// time through seed_we/seed_wdata and takes effect at the next seeding.
module mt19937_random_generator
    import mtrg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        reseed,
    input  logic        seed_we,
    input  logic [31:0] seed_wdata,
    output logic        done,
    output logic [31:0] random_word
);

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_FILL    = 5'b00010,
        ST_TW_PRE  = 5'b00100,
        ST_TWIST   = 5'b01000,
        ST_RD_DATA = 5'b10000
    } state_t;

    function automatic logic [31:0] twist_word(
        input logic [31:0] cur,
        input logic [31:0] nxt,
        input logic [31:0] far
    );
        logic [31:0] y;
        y = (cur & UPPER_MASK) | (nxt & LOWER_MASK);
        return far ^ (y >> 1) ^ (nxt[0] ? MATRIX_A : 32'd0);
    endfunction

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   pos_reg, pos_next;
    logic               seeded_reg, seeded_next;
    logic [31:0]        seed_reg;
    logic [31:0]        x_reg, x_next;
    logic [31:0]        cur_reg;
    logic [31:0]        rd_a_reg, rd_b_reg;
    logic [31:0]        table_mem [TABLE_WORDS];

    logic [ADDR_W-1:0]  addr_a, addr_b, wr_addr;
    logic               wr_en;
    logic [31:0]        wr_data;
    logic               accept;
    logic [CNT_W:0]     far_sum;

    assign busy   = !(state_reg == ST_IDLE || state_reg == ST_RD_DATA);
    assign accept = start && !busy;

    // far operand of the twist: (i + offset) mod table length
    assign far_sum = {1'b0, cnt_reg} + (CNT_W + 1)'(TWIST_OFFSET);
    assign addr_b  = (far_sum >= (CNT_W + 1)'(TABLE_WORDS))
                   ? ADDR_W'(far_sum - (CNT_W + 1)'(TABLE_WORDS))
                   : ADDR_W'(far_sum);

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        pos_next    = pos_reg;
        seeded_next = seeded_reg;
        x_next      = x_reg;
        addr_a      = '0;
        wr_en       = 1'b0;
        wr_addr     = cnt_reg[ADDR_W-1:0];
        wr_data     = x_reg;

        case (state_reg)
            ST_IDLE, ST_RD_DATA:
            begin
                state_next = ST_IDLE;
                if (accept)
                begin
                    if (!seeded_reg || reseed)
                    begin
                        seeded_next = 1'b1;
                        x_next      = seed_reg | 32'd1;
                        cnt_next    = '0;
                        state_next  = ST_FILL;
                    end
                    else if (pos_reg == CNT_W'(TABLE_WORDS))
                    begin
                        state_next = ST_TW_PRE;
                    end
                    else
                    begin
                        addr_a     = pos_reg[ADDR_W-1:0];
                        pos_next   = pos_reg + 1'b1;
                        state_next = ST_RD_DATA;
                    end
                end
            end
            ST_FILL:
            begin
                wr_en    = 1'b1;
                wr_addr  = cnt_reg[ADDR_W-1:0];
                wr_data  = x_reg;
                x_next   = x_reg * SEED_MULT;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(TABLE_WORDS - 1))
                begin
                    state_next = ST_TW_PRE;
                end
            end
            ST_TW_PRE:
            begin
                // fetch word 0 as the first "cur" operand
                addr_a     = '0;
                cnt_next   = '0;
                state_next = ST_TWIST;
            end
            ST_TWIST:
            begin
                // issue reads for step cnt, write result of step cnt-1;
                // the last cycle also issues the read of new word 0
                addr_a   = (cnt_reg >= CNT_W'(TABLE_WORDS - 1))
                         ? '0 : ADDR_W'(cnt_reg + 1'b1);
                wr_en    = (cnt_reg != '0);
                wr_addr  = ADDR_W'(cnt_reg - 1'b1);
                wr_data  = twist_word(cur_reg, rd_a_reg, rd_b_reg);
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(TABLE_WORDS))
                begin
                    pos_next   = CNT_W'(1);
                    state_next = ST_RD_DATA;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            pos_reg    <= '0;
            seeded_reg <= 1'b0;
            seed_reg   <= SEED_RESET;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            pos_reg    <= pos_next;
            seeded_reg <= seeded_next;
            if (seed_we)
            begin
                seed_reg <= seed_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        if (state_reg == ST_TWIST)
        begin
            cur_reg <= rd_a_reg;
        end
    end

    // table memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= table_mem[addr_a];
        rd_b_reg <= table_mem[addr_b];
    end

    mtrg_output_stage u_output_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (state_reg == ST_RD_DATA),
        .raw_word (rd_a_reg),
        .done     (done),
        .word     (random_word)
    );

    a_done_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_RD_DATA))
        else $error("result strobe without a table read");

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= CNT_W'(TABLE_WORDS))
        else $error("read position beyond table");

    a_twist_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TWIST && wr_en) |-> (wr_addr != addr_a && wr_addr != addr_b))
        else $error("twist write collides with a read in flight");

    a_twist_starts_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TWIST && cnt_reg == '0) |-> $past(state_reg == ST_TW_PRE))
        else $error("twist pass entered without prefetch");

    a_fill_seeded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL) |-> seeded_reg)
        else $error("table fill without seeded flag");

endmodule
